[src/spq_pkg.sv]
`default_nettype none
package spq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int PRIORITY_BITS = 16;
   localparam int DATA_BITS     = 32;
   localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [DATA_BITS-1:0]     data;
      logic [PRIORITY_BITS-1:0] prio;
   } spq_entry_type;

   typedef struct packed {
      logic                     push;
      logic                     pop;
      logic [DATA_BITS-1:0]     new_data;
      logic [PRIORITY_BITS-1:0] new_prio;
   } spq_ctrl_type;

endpackage
`default_nettype wire

[src/spq_req_if.sv]
`default_nettype none
interface spq_req_if
   import spq_pkg::*;
   ();
   logic                            valid;
   logic                            ready;
   logic                            mode;
   logic signed [DATA_BITS-1:0]     item_data;
   logic        [PRIORITY_BITS-1:0] item_priority;

   modport source (output valid, mode, item_data, item_priority, input ready);
   modport sink   (input valid, mode, item_data, item_priority, output ready);
endinterface
`default_nettype wire

[src/spq_rsp_if.sv]
`default_nettype none
interface spq_rsp_if
   import spq_pkg::*;
   ();
   logic                            valid;
   logic                            ready;
   logic signed [DATA_BITS-1:0]     removed_data;
   logic signed [DATA_BITS-1:0]     front_data;
   logic        [PRIORITY_BITS-1:0] front_priority;
   logic        [COUNT_BITS-1:0]    entry_count;
   logic                            empty_flag;
   logic        [1:0]               status;

   modport source (output valid, removed_data, front_data, front_priority,
                   entry_count, empty_flag, status, input ready);
   modport sink   (input valid, removed_data, front_data, front_priority,
                   entry_count, empty_flag, status, output ready);
endinterface
`default_nettype wire

[src/spq_cell.sv]
`default_nettype none
module spq_cell
   import spq_pkg::*;
(
   input  wire logic          clock,
   input  wire spq_ctrl_type  ctrl,
   input  wire logic          occupied,
   input  wire spq_entry_type left_entry,
   input  wire logic          left_less,
   input  wire spq_entry_type right_entry,
   output      logic          less,
   output      spq_entry_type entry,
   output      spq_entry_type entry_next
);

   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   assign less = occupied && (entry_ff.prio < ctrl.new_prio);

   // A push keeps entries ahead of the insertion point, drops the new item
   // into the first cell that is not ahead, and shifts the rest right.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         if (!less) begin
            if (left_less) begin
               entry_in.data = ctrl.new_data;
               entry_in.prio = ctrl.new_prio;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (ctrl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule
`default_nettype wire

[src/sorted_priority_queue_top.sv]
// Results show in the cycle after their items are accepted. Every cell compares
// and shifts at once: one push or pop per cycle, unless a result waits.
// The response register frees the input as soon as its item is taken.
// Reset (synchronous, active high) empties the queue and the response register.
// Slot contents are not cleared; only slots below the count are ever shown.
`default_nettype none
module sorted_priority_queue_top
   import spq_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   logic signed [DATA_BITS-1:0]     removed_ff;
   logic signed [DATA_BITS-1:0]     front_data_ff;
   logic        [PRIORITY_BITS-1:0] front_prio_ff;
   logic        [COUNT_BITS-1:0]    rsp_count_ff;
   logic        [1:0]               status_ff;
   logic        [1:0]               status_in;

   logic         accept;
   logic         full;
   logic         empty;
   spq_ctrl_type ctrl;

   spq_entry_type entry_q    [QUEUE_DEPTH];
   spq_entry_type entry_next [QUEUE_DEPTH];
   logic          less       [QUEUE_DEPTH];

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign empty        = (count_ff == '0);

   always_comb begin
      ctrl.push     = accept && (req_ch.mode == MODE_PUSH) && !full;
      ctrl.pop      = accept && (req_ch.mode == MODE_POP) && !empty;
      ctrl.new_data = req_ch.item_data;
      ctrl.new_prio = req_ch.item_priority;
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic          occupied;
      spq_entry_type left_entry;
      logic          left_less;
      spq_entry_type right_entry;

      assign occupied = (COUNT_BITS'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_entry = entry_q[0];
         assign left_less  = 1'b1;
      end else begin : g_body
         assign left_entry = entry_q[i-1];
         assign left_less  = less[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = entry_q[i];
      end else begin : g_mid
         assign right_entry = entry_q[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied),
         .left_entry  (left_entry),
         .left_less   (left_less),
         .right_entry (right_entry),
         .less        (less[i]),
         .entry       (entry_q[i]),
         .entry_next  (entry_next[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_comb begin
      status_in = STATUS_OK;
      if (req_ch.mode == MODE_PUSH && full) begin
         status_in = STATUS_FULL;
      end else if (req_ch.mode == MODE_POP && empty) begin
         status_in = STATUS_EMPTY;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         removed_ff    <= ctrl.pop ? entry_q[0].data : '0;
         front_data_ff <= (count_in != '0) ? entry_next[0].data : '0;
         front_prio_ff <= (count_in != '0) ? entry_next[0].prio : '0;
         rsp_count_ff  <= count_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.removed_data   = removed_ff;
   assign rsp_ch.front_data     = front_data_ff;
   assign rsp_ch.front_priority = front_prio_ff;
   assign rsp_ch.entry_count    = rsp_count_ff;
   assign rsp_ch.empty_flag     = (rsp_count_ff == '0);
   assign rsp_ch.status         = status_ff;

endmodule
`default_nettype wire

[src/spq_checker.sv]
`default_nettype none
module spq_checker
   import spq_pkg::*;
(
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic signed [DATA_BITS-1:0]     rsp_removed_data,
   input wire logic signed [DATA_BITS-1:0]     rsp_front_data,
   input wire logic        [PRIORITY_BITS-1:0] rsp_front_priority,
   input wire logic        [COUNT_BITS-1:0]    rsp_entry_count,
   input wire logic                            rsp_empty_flag,
   input wire logic        [1:0]               rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("A waiting result item was dropped.");

   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_flag |-> rsp_front_data == '0 && rsp_front_priority == '0)
      else $error("An empty queue shows a nonzero front entry.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("The entry count exceeds the queue depth.");

   a_refused_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_removed_data == '0)
      else $error("A refused item reports removed data.");

   a_status_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != STATUS_EMPTY || rsp_empty_flag) &&
                    (rsp_status != STATUS_FULL ||
                     rsp_entry_count == COUNT_BITS'(QUEUE_DEPTH)))
      else $error("The status disagrees with the entry count.");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_removed_data   (rsp_ch.removed_data),
   .rsp_front_data     (rsp_ch.front_data),
   .rsp_front_priority (rsp_ch.front_priority),
   .rsp_entry_count    (rsp_ch.entry_count),
   .rsp_empty_flag     (rsp_ch.empty_flag),
   .rsp_status         (rsp_ch.status)
);
`default_nettype wire

[bench/sorted_priority_queue_top_tb.sv]
`timescale 1ns / 1ps
module sorted_priority_queue_top_tb;
   import spq_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 2000;
   localparam int QUIET_ITEMS    = 200;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] removed_data;
      logic signed [DATA_BITS-1:0] front_data;
      logic [PRIORITY_BITS-1:0]    front_priority;
      logic [COUNT_BITS-1:0]       entry_count;
      logic                        empty_flag;
      logic [1:0]                  status;
   } queue_view_type;

   class sorted_queue_tracker;
      spq_entry_type  slots[QUEUE_DEPTH];
      int             count;
      queue_view_type awaited_views[$];
      int             errors;

      function new();
         count  = 0;
         errors = 0;
      endfunction

      function int pending();
         return awaited_views.size();
      endfunction

      // The queue is kept in ascending priority order, with a new entry placed
      // ahead of every entry of equal priority.
      function void note_request(logic mode, logic signed [DATA_BITS-1:0] data,
                                 logic [PRIORITY_BITS-1:0] prio);
         queue_view_type view;
         int pos;
         int k;
         view = '0;
         if (mode == MODE_PUSH) begin
            if (count >= QUEUE_DEPTH) begin
               view.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < count && slots[pos].prio < prio) pos++;
               for (k = count; k > pos; k--) slots[k] = slots[k-1];
               slots[pos].data = data;
               slots[pos].prio = prio;
               count++;
               view.status = STATUS_OK;
            end
         end else if (count == 0) begin
            view.status = STATUS_EMPTY;
         end else begin
            view.removed_data = slots[0].data;
            for (k = 1; k < count; k++) slots[k-1] = slots[k];
            count--;
            view.status = STATUS_OK;
         end
         if (count > 0) begin
            view.front_data     = slots[0].data;
            view.front_priority = slots[0].prio;
         end
         view.entry_count = COUNT_BITS'(count);
         view.empty_flag  = (count == 0);
         awaited_views.push_back(view);
      endfunction

      function void check_response(queue_view_type got);
         queue_view_type want;
         if (awaited_views.size() == 0) begin
            $error("Result item arrived with no request outstanding.");
            errors++;
            return;
         end
         want = awaited_views.pop_front();
         if (got.removed_data !== want.removed_data) begin
            $error("removed_data: expected %0d, actual %0d", want.removed_data,
                   got.removed_data);
            errors++;
         end
         if (got.front_data !== want.front_data) begin
            $error("front_data: expected %0d, actual %0d", want.front_data,
                   got.front_data);
            errors++;
         end
         if (got.front_priority !== want.front_priority) begin
            $error("front_priority: expected %0d, actual %0d", want.front_priority,
                   got.front_priority);
            errors++;
         end
         if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   got.entry_count);
            errors++;
         end
         if (got.empty_flag !== want.empty_flag) begin
            $error("empty_flag: expected %0d, actual %0d", want.empty_flag,
                   got.empty_flag);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet_tail = 1'b0;
   int   stall_left = 0;
   int   stuck_cycles = 0;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   sorted_queue_tracker tracker = new();

   sorted_priority_queue_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_item(input logic mode, input logic signed [DATA_BITS-1:0] data,
                            input logic [PRIORITY_BITS-1:0] prio);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.mode          <= mode;
      req_ch.item_data     <= data;
      req_ch.item_priority <= prio;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tracker.note_request(mode, data, prio);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 6);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      queue_view_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.removed_data   = rsp_ch.removed_data;
         got.front_data     = rsp_ch.front_data;
         got.front_priority = rsp_ch.front_priority;
         got.entry_count    = rsp_ch.entry_count;
         got.empty_flag     = rsp_ch.empty_flag;
         got.status         = rsp_ch.status;
         tracker.check_response(got);
      end
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("sorted_priority_queue_top regression: fail");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int i;
      int seg_left;
      int push_pct;
      logic [PRIORITY_BITS-1:0] prio;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.mode          = MODE_PUSH;
      req_ch.item_data     = '0;
      req_ch.item_priority = '0;
      rsp_ch.ready         = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: empty pop, push into empty, extreme data and priorities,
      // ties that must put the newest first, a full queue and a refused push.
      send_item(MODE_POP, 32'sh0, 16'h0);
      send_item(MODE_PUSH, 32'sh7fffffff, 16'hffff);
      send_item(MODE_PUSH, -32'sh80000000, 16'h0000);
      send_item(MODE_PUSH, 32'sh0, 16'h0000);
      send_item(MODE_PUSH, -32'sh1, 16'h8000);
      send_item(MODE_POP, 32'sh55aa55aa, 16'h1234);
      send_item(MODE_POP, 32'sh0, 16'h0);
      for (i = 0; i < 14; i++) begin
         send_item(MODE_PUSH, DATA_BITS'(32'h5a5a0000 ^ i),
                   PRIORITY_BITS'(100 * (i % 3)));
      end
      send_item(MODE_PUSH, 32'sh1234, 16'h0001);
      send_item(MODE_POP, -32'sh1, 16'hffff);

      seg_left = 0;
      push_pct = 50;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) begin
            req_ch.valid <= 1'b0;
            while (tracker.pending() != 0) @(negedge clock);
         end
         quiet_tail = (i >= RANDOM_ITEMS - QUIET_ITEMS);
         if (seg_left == 0) begin
            seg_left = $urandom_range(8, 48);
            case ($urandom_range(0, 4))
               0: begin
                  push_pct = 100;
               end
               1: begin
                  push_pct = 0;
               end
               2: begin
                  push_pct = 80;
               end
               3: begin
                  push_pct = 20;
               end
               default: begin
                  push_pct = 50;
               end
            endcase
         end
         seg_left--;
         case ($urandom_range(0, 3))
            0: begin
               prio = PRIORITY_BITS'($urandom_range(0, 7));
            end
            1: begin
               prio = ($urandom_range(0, 1) == 0) ? '0 : '1;
            end
            default: begin
               prio = PRIORITY_BITS'($urandom);
            end
         endcase
         send_item(($urandom_range(1, 100) <= push_pct) ? MODE_PUSH : MODE_POP,
                   DATA_BITS'($urandom), prio);
      end

      req_ch.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("sorted_priority_queue_top regression: pass");
      end else begin
         $display("sorted_priority_queue_top regression: fail");
      end
      $finish;
   end

endmodule
